### rtl/flash_wear_level_value_log_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wear-levelled value log.
// Every property is clocked on clk and is held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef FLASH_WEAR_LEVEL_VALUE_LOG_CORE_ASSERT_SVH
`define FLASH_WEAR_LEVEL_VALUE_LOG_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fwl_pkg.sv
// ----------------------------------------------------------------------------
// fwl_pkg
// Types, constants and helper functions shared by the value log modules.
// ----------------------------------------------------------------------------
package fwl_pkg;

  localparam int SLOTS_PER_GROUP     = 8;
  localparam int SLOT_BITS           = 3;
  localparam int SLOT_PTR_W          = 4;
  localparam int DEF_GROUPS_PER_PAGE = 8;
  localparam int DEF_PAGES_PER_STORE = 16;

  localparam logic [7:0]  FREE_ERASED     = 8'hFF;
  localparam logic [7:0]  FREE_ALL_USED   = 8'h00;
  localparam logic [15:0] INIT_LAST_VALUE = 16'd1440;
  localparam logic [15:0] INIT_VALUE      = 16'd0;

  localparam logic FUNC_SAVE    = 1'b0;
  localparam logic FUNC_RESTORE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ERASE,
    ST_SAVE_RD,
    ST_SAVE_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FETCH
  } fwl_state_t;

  typedef struct packed {
    logic map_we;
    logic slot_we;
  } fwl_mem_req_t;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Highest slot whose free bit is cleared.
  function automatic logic [SLOT_BITS-1:0] last_used(input logic [7:0] map);
    logic [SLOT_BITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
      if (!map[i]) begin
        idx = SLOT_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/fwl_store.sv
// ----------------------------------------------------------------------------
// fwl_store
// Slot value memory and per-group free map memory, one port each with
// registered read data.
// ----------------------------------------------------------------------------
module fwl_store
  import fwl_pkg::*;
#(
  parameter int GROUPS_PER_PAGE = DEF_GROUPS_PER_PAGE,
  parameter int PAGES_PER_STORE = DEF_PAGES_PER_STORE
) (
  input  logic                                          clk,
  input  fwl_mem_req_t                                  mem_req,
  input  logic [idx_width(GROUPS_PER_PAGE*PAGES_PER_STORE)-1:0] map_addr,
  input  logic [7:0]                                    map_wdata,
  output logic [7:0]                                    map_rdata,
  input  logic [idx_width(GROUPS_PER_PAGE*PAGES_PER_STORE)+SLOT_BITS-1:0] slot_addr,
  input  logic [15:0]                                   slot_wdata,
  output logic [15:0]                                   slot_rdata
);

  localparam int GROUP_COUNT = GROUPS_PER_PAGE * PAGES_PER_STORE;
  localparam int SLOT_COUNT  = GROUP_COUNT * SLOTS_PER_GROUP;

  logic [7:0]  map_mem  [GROUP_COUNT];
  logic [15:0] slot_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (mem_req.map_we) begin
      map_mem[map_addr] <= map_wdata;
    end
    map_rdata <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_req.slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_addr];
  end

endmodule

### rtl/fwl_ctrl.sv
// ----------------------------------------------------------------------------
// fwl_ctrl
// Sequencer of the value log: clearing pass, save with page and store erase,
// backward restore scan. One group address unit serves every state but the clearing pass, which uses its own counter.
// ----------------------------------------------------------------------------
module fwl_ctrl
  import fwl_pkg::*;
#(
  parameter int GROUPS_PER_PAGE = DEF_GROUPS_PER_PAGE,
  parameter int PAGES_PER_STORE = DEF_PAGES_PER_STORE
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic                                          func,
  input  logic [15:0]                                   value,
  output logic                                          busy,
  output logic                                          done,
  output logic [15:0]                                   result_value,
  output logic                                          found,
  output logic                                          erased,
  output logic [3:0]                                    page_pos,
  output logic [2:0]                                    group_pos,
  output logic [2:0]                                    slot_pos,
  output fwl_mem_req_t                                  mem_req,
  output logic [idx_width(GROUPS_PER_PAGE*PAGES_PER_STORE)-1:0] map_addr,
  output logic [7:0]                                    map_wdata,
  input  logic [7:0]                                    map_rdata,
  output logic [idx_width(GROUPS_PER_PAGE*PAGES_PER_STORE)+SLOT_BITS-1:0] slot_addr,
  output logic [15:0]                                   slot_wdata,
  input  logic [15:0]                                   slot_rdata
);

  localparam int GROUP_COUNT = GROUPS_PER_PAGE * PAGES_PER_STORE;
  localparam int SLOT_COUNT  = GROUP_COUNT * SLOTS_PER_GROUP;
  localparam int GW  = idx_width(GROUPS_PER_PAGE);
  localparam int PW  = idx_width(PAGES_PER_STORE);
  localparam int GIW = idx_width(GROUP_COUNT);
  localparam int SAW = GIW + SLOT_BITS;

  localparam logic [GW-1:0]  LAST_GROUP     = GW'(GROUPS_PER_PAGE - 1);
  localparam logic [PW-1:0]  LAST_PAGE      = PW'(PAGES_PER_STORE - 1);
  localparam logic [SAW-1:0] LAST_SLOT_ADDR = SAW'(SLOT_COUNT - 1);
  localparam logic [SLOT_PTR_W-1:0] SLOT_END = SLOT_PTR_W'(SLOTS_PER_GROUP);

  fwl_state_t state, state_next;
  logic [PW-1:0]         page_ptr, page_ptr_next;
  logic [GW-1:0]         group_ptr, group_ptr_next;
  logic [SLOT_PTR_W-1:0] slot_ptr, slot_ptr_next;
  logic [15:0]           held_value, held_value_next;
  logic [SAW-1:0]        clr, clr_next;
  logic                  done_next;

  logic [15:0]           value_q, value_q_next;
  logic                  erase_full, erase_full_next;
  logic                  erased_q, erased_q_next;
  logic [15:0]           result_value_next;
  logic                  found_next;
  logic                  erased_next;
  logic [3:0]            page_pos_next;
  logic [2:0]            group_pos_next;
  logic [2:0]            slot_pos_next;

  logic [GIW-1:0]        gi;
  logic [SLOT_BITS-1:0]  hit_slot;

  assign gi = GIW'(32'(page_ptr) * GROUPS_PER_PAGE) + GIW'(group_ptr);
  assign hit_slot = last_used(map_rdata);
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      page_ptr   <= '0;
      group_ptr  <= '0;
      slot_ptr   <= '0;
      held_value <= '0;
      clr        <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      page_ptr   <= page_ptr_next;
      group_ptr  <= group_ptr_next;
      slot_ptr   <= slot_ptr_next;
      held_value <= held_value_next;
      clr        <= clr_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    value_q      <= value_q_next;
    erase_full   <= erase_full_next;
    erased_q     <= erased_q_next;
    result_value <= result_value_next;
    found        <= found_next;
    erased       <= erased_next;
    page_pos     <= page_pos_next;
    group_pos    <= group_pos_next;
    slot_pos     <= slot_pos_next;
  end

  always_comb begin
    state_next        = state;
    page_ptr_next     = page_ptr;
    group_ptr_next    = group_ptr;
    slot_ptr_next     = slot_ptr;
    held_value_next   = held_value;
    clr_next          = clr;
    done_next         = 1'b0;
    value_q_next      = value_q;
    erase_full_next   = erase_full;
    erased_q_next     = erased_q;
    result_value_next = result_value;
    found_next        = found;
    erased_next       = erased;
    page_pos_next     = page_pos;
    group_pos_next    = group_pos;
    slot_pos_next     = slot_pos;
    mem_req           = '0;
    map_addr          = gi;
    map_wdata         = FREE_ERASED;
    slot_addr         = {gi, slot_ptr[SLOT_BITS-1:0]};
    slot_wdata        = value_q;

    case (state)
      ST_CLEAR: begin
        mem_req.slot_we = 1'b1;
        slot_addr       = clr;
        slot_wdata      = (clr == LAST_SLOT_ADDR) ? INIT_LAST_VALUE : INIT_VALUE;
        mem_req.map_we  = (clr[SLOT_BITS-1:0] == '0);
        map_addr        = clr[SAW-1:SLOT_BITS];
        map_wdata       = FREE_ALL_USED;
        if (clr == LAST_SLOT_ADDR) begin
          state_next = ST_IDLE;
        end else begin
          clr_next = clr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          value_q_next = value;
          if (func == FUNC_RESTORE) begin
            page_ptr_next  = LAST_PAGE;
            group_ptr_next = LAST_GROUP;
            state_next     = ST_SCAN_RD;
          end else begin
            erased_q_next = 1'b0;
            state_next    = ST_SAVE_RD;
            if (slot_ptr >= SLOT_END) begin
              slot_ptr_next = '0;
              if (group_ptr == LAST_GROUP) begin
                group_ptr_next = '0;
                state_next     = ST_ERASE;
                if (page_ptr == LAST_PAGE) begin
                  page_ptr_next   = '0;
                  erase_full_next = 1'b1;
                  erased_q_next   = 1'b1;
                end else begin
                  page_ptr_next   = page_ptr + 1'b1;
                  erase_full_next = 1'b0;
                end
              end else begin
                group_ptr_next = group_ptr + 1'b1;
              end
            end
          end
        end
      end

      ST_ERASE: begin
        mem_req.map_we = 1'b1;
        map_wdata      = FREE_ERASED;
        if (group_ptr == LAST_GROUP) begin
          group_ptr_next = '0;
          if (erase_full && (page_ptr != LAST_PAGE)) begin
            page_ptr_next = page_ptr + 1'b1;
          end else begin
            if (erase_full) begin
              page_ptr_next = '0;
            end
            state_next = ST_SAVE_RD;
          end
        end else begin
          group_ptr_next = group_ptr + 1'b1;
        end
      end

      ST_SAVE_RD: begin
        state_next = ST_SAVE_WR;
      end

      ST_SAVE_WR: begin
        mem_req.map_we    = 1'b1;
        mem_req.slot_we   = 1'b1;
        map_wdata         = map_rdata & ~(8'b1 << slot_ptr[SLOT_BITS-1:0]);
        held_value_next   = value_q;
        done_next         = 1'b1;
        result_value_next = value_q;
        found_next        = 1'b1;
        erased_next       = erased_q;
        page_pos_next     = 4'(page_ptr);
        group_pos_next    = 3'(group_ptr);
        slot_pos_next     = slot_ptr[SLOT_BITS-1:0];
        slot_ptr_next     = slot_ptr + 1'b1;
        state_next        = ST_IDLE;
      end

      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (map_rdata != FREE_ERASED) begin
          slot_addr     = {gi, hit_slot};
          slot_ptr_next = SLOT_PTR_W'(hit_slot) + 1'b1;
          state_next    = ST_FETCH;
        end else if ((page_ptr == '0) && (group_ptr == '0)) begin
          slot_ptr_next     = '0;
          done_next         = 1'b1;
          result_value_next = held_value;
          found_next        = 1'b0;
          erased_next       = 1'b0;
          page_pos_next     = '0;
          group_pos_next    = '0;
          slot_pos_next     = '0;
          state_next        = ST_IDLE;
        end else begin
          if (group_ptr == '0) begin
            group_ptr_next = LAST_GROUP;
            page_ptr_next  = page_ptr - 1'b1;
          end else begin
            group_ptr_next = group_ptr - 1'b1;
          end
          state_next = ST_SCAN_RD;
        end
      end

      ST_FETCH: begin
        held_value_next   = slot_rdata;
        done_next         = 1'b1;
        result_value_next = slot_rdata;
        found_next        = 1'b1;
        erased_next       = 1'b0;
        page_pos_next     = 4'(page_ptr);
        group_pos_next    = 3'(group_ptr);
        slot_pos_next     = 3'(slot_ptr - 1'b1);
        state_next        = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/flash_wear_level_value_log_core.sv
// ----------------------------------------------------------------------------
// flash_wear_level_value_log_core
// Wear-levelled append log of 16-bit values with save and restore commands.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 8 * GROUPS_PER_PAGE *
// PAGES_PER_STORE slots (1024 by default) with busy high, loading the
// initial image. A command is taken when start is high and busy is low,
// and its single result beat appears with done high for one cycle, which the
// receiver must take. A save reads the free map of its group and then writes
// the slot and the updated map; before that it erases the free map of the
// new page when it steps into one, and of the whole store when it wraps. A
// restore scans the groups from the top of the store down, reading the free
// map of each once, and fetches the last used slot of the first used group,
// or returns the held value when it finds none. The free map memory has a
// single port.
// ----------------------------------------------------------------------------
module flash_wear_level_value_log_core
  import fwl_pkg::*;
#(
  parameter int GROUPS_PER_PAGE = DEF_GROUPS_PER_PAGE,
  parameter int PAGES_PER_STORE = DEF_PAGES_PER_STORE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] value,
  output logic        done,
  output logic [15:0] result_value,
  output logic        found,
  output logic        erased,
  output logic [3:0]  page_pos,
  output logic [2:0]  group_pos,
  output logic [2:0]  slot_pos
);

  localparam int GIW = idx_width(GROUPS_PER_PAGE * PAGES_PER_STORE);

  fwl_mem_req_t             mem_req;
  logic [GIW-1:0]           map_addr;
  logic [7:0]               map_wdata;
  logic [7:0]               map_rdata;
  logic [GIW+SLOT_BITS-1:0] slot_addr;
  logic [15:0]              slot_wdata;
  logic [15:0]              slot_rdata;

  fwl_ctrl #(
    .GROUPS_PER_PAGE(GROUPS_PER_PAGE),
    .PAGES_PER_STORE(PAGES_PER_STORE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .value        (value),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .found        (found),
    .erased       (erased),
    .page_pos     (page_pos),
    .group_pos    (group_pos),
    .slot_pos     (slot_pos),
    .mem_req      (mem_req),
    .map_addr     (map_addr),
    .map_wdata    (map_wdata),
    .map_rdata    (map_rdata),
    .slot_addr    (slot_addr),
    .slot_wdata   (slot_wdata),
    .slot_rdata   (slot_rdata)
  );

  fwl_store #(
    .GROUPS_PER_PAGE(GROUPS_PER_PAGE),
    .PAGES_PER_STORE(PAGES_PER_STORE)
  ) u_store (
    .clk        (clk),
    .mem_req    (mem_req),
    .map_addr   (map_addr),
    .map_wdata  (map_wdata),
    .map_rdata  (map_rdata),
    .slot_addr  (slot_addr),
    .slot_wdata (slot_wdata),
    .slot_rdata (slot_rdata)
  );

endmodule

### rtl/fwl_checker.sv
// ----------------------------------------------------------------------------
// fwl_checker
// Port-level checks of the value log, bound to the top level.
// ----------------------------------------------------------------------------
`include "flash_wear_level_value_log_core_assert.svh"

module fwl_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        found,
  input logic        erased,
  input logic [3:0]  page_pos,
  input logic [2:0]  group_pos,
  input logic [2:0]  slot_pos
);

  `FWL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `FWL_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result beat without a command in work")
  `FWL_ASSERT_NEXT(a_done_single, done, !done, "result beat lasted more than one cycle")
  `FWL_ASSERT_SAME(a_miss_zero, done && !found, !erased && page_pos == 4'd0 && group_pos == 3'd0 && slot_pos == 3'd0, "restore miss with nonzero position")
  `FWL_ASSERT_SAME(a_erase_start, done && erased, found && page_pos == 4'd0 && group_pos == 3'd0 && slot_pos == 3'd0, "erasing save not at the first slot")

endmodule

bind flash_wear_level_value_log_core fwl_checker u_fwl_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .found     (found),
  .erased    (erased),
  .page_pos  (page_pos),
  .group_pos (group_pos),
  .slot_pos  (slot_pos)
);
